### hdl/assert_macros.svh
// Shared concurrent assertion helpers; the using module provides clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SEE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication.
`define SEE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### hdl/see_pkg.sv
`default_nettype none

package see_pkg;

	localparam int ADDR_WIDTH = 17;
	localparam int MEM_DEPTH  = 2 ** ADDR_WIDTH;

	typedef logic [ADDR_WIDTH-1:0] addr_t;
	typedef logic [7:0]            byte_t;

	// Command opcodes
	localparam byte_t OP_WRSR     = 8'h01;
	localparam byte_t OP_WRITE    = 8'h02;
	localparam byte_t OP_READ     = 8'h03;
	localparam byte_t OP_WRDI     = 8'h04;
	localparam byte_t OP_RDSR     = 8'h05;
	localparam byte_t OP_WREN     = 8'h06;
	localparam byte_t OP_WRITE_HI = 8'h0A;
	localparam byte_t OP_READ_HI  = 8'h0B;

	localparam byte_t REPLY_REFUSE = 8'hFF;
	localparam byte_t STATUS_BASE  = 8'hF0;

	// Configuration register indexes (word address bit 2)
	localparam logic REG_ADDR_BYTES = 1'b0;
	localparam logic REG_SIZE_LOG2  = 1'b1;

	localparam logic [1:0] ADDR_BYTES_RESET = 2'd2;
	localparam logic [4:0] SIZE_LOG2_RESET  = 5'd16;

	typedef struct packed {
		logic  rd;
		logic  wr;
		addr_t addr;
		byte_t wdata;
	} mem_req_t;

endpackage

`default_nettype wire

### hdl/see_if.sv
`default_nettype none

interface see_mosi_if;
	logic  valid;
	logic  ready;
	logic  [7:0] data_in;
	logic  hold_select;

	modport source (output valid, output data_in, output hold_select, input ready);
	modport sink   (input valid, input data_in, input hold_select, output ready);
endinterface

interface see_miso_if;
	logic  valid;
	logic  ready;
	logic  [7:0] data_out;

	modport source (output valid, output data_out, input ready);
	modport sink   (input valid, input data_out, output ready);
endinterface

`default_nettype wire

### hdl/see_mem.sv
`default_nettype none
`include "assert_macros.svh"

module see_mem (
	input  wire                clk,
	input  wire                arst_n,
	input  see_pkg::mem_req_t  req,
	output see_pkg::byte_t     rdata_s1,
	output logic               busy
);

	see_pkg::byte_t mem [see_pkg::MEM_DEPTH];

	see_pkg::addr_t clr_addr_q;
	logic           clr_busy_q;

	// Sweep every entry to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= see_pkg::addr_t'(clr_addr_q + 1'b1);
			if (&clr_addr_q) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (req.wr) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd) begin
			rdata_s1 <= mem[req.addr];
		end
	end

	assign busy = clr_busy_q;

	`SEE_ASSERT_NOW(a_no_access_in_clear, clr_busy_q, (!req.wr && !req.rd))
	`SEE_ASSERT_NOW(a_single_access, 1'b1, (!(req.wr && req.rd)))

endmodule

`default_nettype wire

### hdl/see_cmd.sv
`default_nettype none
`include "assert_macros.svh"

module see_cmd (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                accept,
	input  wire  [7:0]         data_in,
	input  wire                hold_select,
	input  wire  [1:0]         address_bytes,
	input  wire  [4:0]         size_log2,
	output see_pkg::mem_req_t  req,
	output see_pkg::byte_t     reply,
	output logic               from_mem
);

	see_pkg::byte_t opcode_q;
	logic [2:0]     cnt_q;
	see_pkg::addr_t addr_q;
	logic           wel_q;
	logic [1:0]     prot_q;
	logic           held_q;

	see_pkg::byte_t op;
	logic [2:0]     cnt;
	logic [2:0]     cnt_n;
	see_pkg::addr_t addr;
	see_pkg::addr_t addr_n;
	see_pkg::addr_t umask;
	see_pkg::addr_t masked;
	see_pkg::addr_t shifted;
	logic           wel_n;
	logic [1:0]     prot_n;
	logic           do_rw;
	logic           rw_write;
	logic           addr_phase;

	always_comb begin
		for (int i = 0; i < see_pkg::ADDR_WIDTH; i++) begin
			umask[i] = (i < int'(size_log2));
		end
	end

	always_comb begin
		// A byte after deselect opens a new command
		op       = held_q ? opcode_q : data_in;
		cnt      = held_q ? cnt_q : 3'd0;
		addr     = held_q ? addr_q : '0;
		wel_n    = wel_q;
		prot_n   = prot_q;
		reply    = '0;
		from_mem = 1'b0;
		do_rw    = 1'b0;
		req      = '0;

		unique case (op) inside
			see_pkg::OP_WREN: begin
				if (hold_select) begin
					reply = see_pkg::REPLY_REFUSE;
				end else begin
					wel_n = 1'b1;
				end
			end
			see_pkg::OP_WRDI: begin
				if (hold_select) begin
					reply = see_pkg::REPLY_REFUSE;
				end else begin
					wel_n = 1'b0;
				end
			end
			see_pkg::OP_RDSR: begin
				reply = see_pkg::STATUS_BASE | {4'b0000, prot_q, wel_q, 1'b0};
			end
			see_pkg::OP_WRSR: begin
				prot_n = data_in[3:2];
			end
			see_pkg::OP_READ_HI, see_pkg::OP_WRITE_HI: begin
				if (address_bytes != 2'd1) begin
					reply = see_pkg::REPLY_REFUSE;
				end else begin
					// Opcode byte carries address bit 8
					if (cnt == 3'd0) begin
						addr = see_pkg::addr_t'(1);
					end
					do_rw = 1'b1;
				end
			end
			see_pkg::OP_READ, see_pkg::OP_WRITE: begin
				do_rw = 1'b1;
			end
			default: begin
				reply = see_pkg::REPLY_REFUSE;
			end
		endcase

		addr_n     = addr;
		rw_write   = (op == see_pkg::OP_WRITE) || (op == see_pkg::OP_WRITE_HI);
		addr_phase = cnt < ({1'b0, address_bytes} + 3'd1);
		shifted    = {addr[see_pkg::ADDR_WIDTH-9:0], data_in};
		masked     = addr & umask;

		if (do_rw) begin
			if (rw_write && !wel_q) begin
				reply = see_pkg::REPLY_REFUSE;
			end else if (addr_phase) begin
				if (cnt != 3'd0) begin
					addr_n = shifted;
				end
			end else begin
				req.addr = masked;
				addr_n   = see_pkg::addr_t'(masked + 1'b1);
				if (rw_write) begin
					req.wr    = accept;
					req.wdata = data_in;
					if (!hold_select) begin
						wel_n = 1'b0;
					end
				end else begin
					req.rd   = accept;
					from_mem = 1'b1;
				end
			end
		end

		cnt_n = (cnt == 3'd7) ? cnt : 3'(cnt + 3'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opcode_q <= '0;
			cnt_q    <= '0;
			addr_q   <= '0;
			wel_q    <= 1'b0;
			prot_q   <= '0;
			held_q   <= 1'b0;
		end else if (accept) begin
			opcode_q <= op;
			cnt_q    <= cnt_n;
			addr_q   <= addr_n;
			wel_q    <= wel_n;
			prot_q   <= prot_n;
			held_q   <= hold_select;
		end
	end

	`SEE_ASSERT_NEXT(a_wel_drop, (req.wr && !hold_select), (!wel_q))

endmodule

`default_nettype wire

### hdl/spi_eeprom_command_engine.sv
`default_nettype none
`include "assert_macros.svh"

// 25xx-style serial EEPROM command engine: each mosi beat is one SPI byte plus a flag
// telling whether chip select stays low, and each beat produces exactly one miso beat
// with the byte shifted back. A new byte is taken every clock unless miso back-pressure
// or the clearing sweep stalls it; its reply is registered in stage 1 (command decode
// and the memory read) when the byte is accepted, then in the output register on miso,
// and the output register with the stage in front of it lets a waiting reply sit while
// the next byte is taken. The 128 KiB array is a single-port synchronous memory; after
// reset a sweep zeroes it one byte per cycle, during which mosi.ready stays low (APB writes
// still work). Write address_bytes (offset 0x0) and size_log2 (offset 0x4) only while
// no bytes are in flight.
module spi_eeprom_command_engine (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire  [2:0]        paddr,
	input  wire  [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	see_mosi_if.sink          mosi,
	see_miso_if.source        miso
);

	logic [1:0]        address_bytes_q;
	logic [4:0]        size_log2_q;

	see_pkg::mem_req_t req;
	see_pkg::byte_t    reply;
	logic              from_mem;
	see_pkg::byte_t    rdata_s1;
	logic              mem_busy;

	logic              vld_s1;
	see_pkg::byte_t    reply_s1;
	logic              from_mem_s1;
	logic              out_vld_q;
	see_pkg::byte_t    out_data_q;

	logic              accept;
	logic              out_load;
	logic              take;

	// Configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_bytes_q <= see_pkg::ADDR_BYTES_RESET;
			size_log2_q     <= see_pkg::SIZE_LOG2_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				see_pkg::REG_ADDR_BYTES: address_bytes_q <= pwdata[1:0];
				see_pkg::REG_SIZE_LOG2:  size_log2_q     <= pwdata[4:0];
				default:                 address_bytes_q <= address_bytes_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			see_pkg::REG_ADDR_BYTES: prdata = {30'd0, address_bytes_q};
			see_pkg::REG_SIZE_LOG2:  prdata = {27'd0, size_log2_q};
			default:                 prdata = '0;
		endcase
	end

	// Handshake: stage 1 advances whenever the output register is free or draining
	assign out_load   = vld_s1 && (!out_vld_q || miso.ready);
	assign take       = !vld_s1 || out_load;
	assign mosi.ready = take && !mem_busy;
	assign accept     = mosi.valid && mosi.ready;

	see_cmd u_cmd (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_in       (mosi.data_in),
		.hold_select   (mosi.hold_select),
		.address_bytes (address_bytes_q),
		.size_log2     (size_log2_q),
		.req           (req),
		.reply         (reply),
		.from_mem      (from_mem)
	);

	see_mem u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rdata_s1 (rdata_s1),
		.busy     (mem_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (out_load) begin
				vld_s1 <= 1'b0;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (miso.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			reply_s1    <= reply;
			from_mem_s1 <= from_mem;
		end
		if (out_load) begin
			out_data_q <= from_mem_s1 ? rdata_s1 : reply_s1;
		end
	end

	assign miso.valid    = out_vld_q;
	assign miso.data_out = out_data_q;

	`SEE_ASSERT_NEXT(a_accept_fills_s1, accept, vld_s1)
	`SEE_ASSERT_NOW(a_stall_blocks_input, (vld_s1 && out_vld_q && !miso.ready), (!mosi.ready))

endmodule

`default_nettype wire

### dv/tb_top.sv
`default_nettype none

module tb_top;

	typedef struct {
		see_pkg::byte_t data;
		logic           hold;
		int unsigned    gap;
	} spi_beat_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	see_mosi_if mosi_bus ();
	see_miso_if miso_bus ();

	spi_eeprom_command_engine uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.mosi    (mosi_bus),
		.miso    (miso_bus)
	);

	always #5 clk = ~clk;

	// Device image mirrored by the checker
	see_pkg::byte_t mem_image [see_pkg::MEM_DEPTH] = '{default: 8'h00};
	see_pkg::byte_t op_reg    = 8'h00;
	logic [2:0]     cmd_len   = 3'd0;
	see_pkg::addr_t cur_addr  = '0;
	logic           wel       = 1'b0;
	logic [1:0]     prot      = 2'b00;
	logic           sel_held  = 1'b0;
	logic [1:0]     cfg_ab    = see_pkg::ADDR_BYTES_RESET;
	logic [4:0]     cfg_size  = see_pkg::SIZE_LOG2_RESET;

	spi_beat_t      mosi_backlog [$];
	see_pkg::byte_t answers_due [$];
	int             n_queued   = 0;
	int             n_accepted = 0;
	int             n_errors   = 0;
	int             phase_no   = -1;

	// Stimulus-side view of the current settings
	logic [1:0]     ph_ab;
	logic           tx_eager = 1'b0;
	see_pkg::addr_t hot_addr [6];

	spi_beat_t      tx_item;
	int unsigned    tx_idle;
	int unsigned    rx_wait;
	int unsigned    rx_pause;
	logic           rx_eager;
	logic           rx_block = 1'b0;
	see_pkg::byte_t want;

	// True once the address bytes are in; shifts the address while they arrive
	function automatic logic addr_done(see_pkg::byte_t val);
		int lim;
		if (int'(cmd_len) < int'(cfg_ab) + 1) begin
			if (cmd_len != 3'd0)
				cur_addr = see_pkg::addr_t'({cur_addr, val});
			return 1'b0;
		end
		lim = (cfg_size > see_pkg::ADDR_WIDTH) ? see_pkg::ADDR_WIDTH : int'(cfg_size);
		cur_addr = cur_addr & see_pkg::addr_t'((32'd1 << lim) - 32'd1);
		return 1'b1;
	endfunction

	function automatic see_pkg::byte_t mem_fetch(see_pkg::byte_t val);
		see_pkg::byte_t r;
		if (!addr_done(val))
			return 8'h00;
		r = mem_image[cur_addr];
		cur_addr = cur_addr + 1'b1;
		return r;
	endfunction

	function automatic see_pkg::byte_t mem_store(see_pkg::byte_t val, logic hold);
		if (!wel)
			return see_pkg::REPLY_REFUSE;
		if (!addr_done(val))
			return 8'h00;
		mem_image[cur_addr] = val;
		cur_addr = cur_addr + 1'b1;
		if (!hold)
			wel = 1'b0;
		return 8'h00;
	endfunction

	function automatic see_pkg::byte_t eeprom_answer(see_pkg::byte_t val, logic hold);
		see_pkg::byte_t r;
		if (!sel_held) begin
			op_reg = val;
			cmd_len = 3'd0;
			cur_addr = '0;
		end
		case (op_reg)
			see_pkg::OP_WREN: begin
				if (hold) r = see_pkg::REPLY_REFUSE;
				else begin
					wel = 1'b1;
					r = 8'h00;
				end
			end
			see_pkg::OP_WRDI: begin
				if (hold) r = see_pkg::REPLY_REFUSE;
				else begin
					wel = 1'b0;
					r = 8'h00;
				end
			end
			see_pkg::OP_RDSR: r = see_pkg::STATUS_BASE | {4'b0000, prot, wel, 1'b0};
			see_pkg::OP_WRSR: begin
				prot = val[3:2];
				r = 8'h00;
			end
			see_pkg::OP_READ_HI, see_pkg::OP_WRITE_HI: begin
				if (cfg_ab != 2'd1) r = see_pkg::REPLY_REFUSE;
				else begin
					// opcode byte seeds a 1 that the address byte shifts up into bit 8
					if (cmd_len == 3'd0)
						cur_addr = see_pkg::addr_t'(1);
					r = (op_reg == see_pkg::OP_READ_HI) ? mem_fetch(val)
						: mem_store(val, hold);
				end
			end
			see_pkg::OP_READ:  r = mem_fetch(val);
			see_pkg::OP_WRITE: r = mem_store(val, hold);
			default:           r = see_pkg::REPLY_REFUSE;
		endcase
		if (cmd_len != 3'd7)
			cmd_len = cmd_len + 1'b1;
		sel_held = hold;
		return r;
	endfunction

	// Sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mosi_bus.valid <= 1'b0;
			mosi_bus.data_in <= 8'h00;
			mosi_bus.hold_select <= 1'b0;
			tx_idle <= 0;
		end else if (!mosi_bus.valid || mosi_bus.ready) begin
			if (tx_idle != 0) begin
				mosi_bus.valid <= 1'b0;
				tx_idle <= tx_idle - 1;
			end else if (mosi_backlog.size() != 0) begin
				tx_item = mosi_backlog.pop_front();
				mosi_bus.valid <= 1'b1;
				mosi_bus.data_in <= tx_item.data;
				mosi_bus.hold_select <= tx_item.hold;
				tx_idle <= tx_item.gap;
			end else begin
				mosi_bus.valid <= 1'b0;
			end
		end
	end

	// Receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miso_bus.ready <= 1'b0;
			rx_wait <= 0;
			rx_eager <= 1'b0;
		end else if (rx_block) begin
			miso_bus.ready <= 1'b0;
		end else if (miso_bus.valid && miso_bus.ready) begin
			if ($urandom_range(0, 29) == 0)
				rx_eager <= !rx_eager;
			rx_pause = rx_eager ? 0 : $urandom_range(0, 9);
			rx_wait <= rx_pause;
			miso_bus.ready <= (rx_pause == 0);
		end else if (rx_wait != 0) begin
			rx_wait <= rx_wait - 1;
			miso_bus.ready <= (rx_wait == 1);
		end else begin
			miso_bus.ready <= 1'b1;
		end
	end

	// Monitor: predict on every accepted byte, compare every reply beat
	always @(posedge clk) begin
		if (arst_n && mosi_bus.valid && mosi_bus.ready) begin
			answers_due.push_back(eeprom_answer(mosi_bus.data_in, mosi_bus.hold_select));
			n_accepted++;
		end
		if (arst_n && miso_bus.valid && miso_bus.ready) begin
			if (answers_due.size() == 0) begin
				$display("%0t: data_out expected none actual 0x%02h", $time,
					miso_bus.data_out);
				n_errors++;
			end else begin
				want = answers_due.pop_front();
				if (miso_bus.data_out !== want) begin
					$display("%0t: data_out expected 0x%02h actual 0x%02h", $time,
						want, miso_bus.data_out);
					n_errors++;
				end
			end
		end
	end

	// Starve the output for a long stretch so the engine backs up into mosi
	initial begin
		wait (phase_no == 2);
		repeat (30) @(posedge clk);
		rx_block <= 1'b1;
		repeat (400) @(posedge clk);
		rx_block <= 1'b0;
	end

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic push_byte(see_pkg::byte_t d, logic h);
		mosi_backlog.push_back('{d, h, tx_eager ? 0 : $urandom_range(0, 9)});
		n_queued++;
	endtask

	task automatic reg_write(logic idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == see_pkg::REG_ADDR_BYTES)
			cfg_ab = value[1:0];
		else
			cfg_size = value[4:0];
	endtask

	// Junk in the upper bits must be ignored
	task automatic set_config(logic [1:0] ab, logic [4:0] size);
		reg_write(see_pkg::REG_ADDR_BYTES,
			{$urandom_range(0, 1) ? 30'($urandom) : 30'd0, ab});
		reg_write(see_pkg::REG_SIZE_LOG2,
			{$urandom_range(0, 1) ? 27'($urandom) : 27'd0, size});
		ph_ab = ab;
	endtask

	// Hold off until every byte is taken and every reply has come back
	task automatic drain();
		while (n_accepted != n_queued || answers_due.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic gen_command();
		see_pkg::byte_t frame [$];
		see_pkg::byte_t op;
		logic [23:0]    a24;
		int unsigned    kind;
		int unsigned    n;
		logic           hi;
		tx_eager = (phase_no == 2) || ($urandom_range(0, 9) < 3);
		if ($urandom_range(0, 15) == 0)
			hot_addr[$urandom_range(0, 5)] = see_pkg::addr_t'($urandom);
		a24 = {7'($urandom), hot_addr[$urandom_range(0, 5)]};
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			frame.push_back(see_pkg::OP_WREN);
		end else if (kind < 14) begin
			frame.push_back(see_pkg::OP_WRDI);
		end else if (kind < 18) begin
			// enable/disable with select held is refused
			frame.push_back($urandom_range(0, 1) ? see_pkg::OP_WREN : see_pkg::OP_WRDI);
			frame.push_back(see_pkg::byte_t'($urandom));
		end else if (kind < 26) begin
			frame.push_back(see_pkg::OP_RDSR);
			repeat ($urandom_range(0, 2)) frame.push_back(see_pkg::byte_t'($urandom));
		end else if (kind < 31) begin
			frame.push_back(see_pkg::OP_WRSR);
			repeat ($urandom_range(0, 2)) frame.push_back(see_pkg::byte_t'($urandom));
		end else if (kind < 90 && kind >= 85) begin
			do op = see_pkg::byte_t'($urandom);
			while (op inside {see_pkg::OP_WRSR, see_pkg::OP_WRITE, see_pkg::OP_READ,
				see_pkg::OP_WRDI, see_pkg::OP_RDSR, see_pkg::OP_WREN,
				see_pkg::OP_WRITE_HI, see_pkg::OP_READ_HI});
			frame.push_back(op);
			repeat ($urandom_range(0, 2)) frame.push_back(see_pkg::byte_t'($urandom));
		end else if (kind < 85) begin
			hi = (ph_ab == 2'd1) ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 9) == 0);
			if (kind < 58) begin
				if ($urandom_range(0, 4) != 0)
					push_byte(see_pkg::OP_WREN, 1'b0);
				frame.push_back(hi ? see_pkg::OP_WRITE_HI : see_pkg::OP_WRITE);
			end else begin
				frame.push_back(hi ? see_pkg::OP_READ_HI : see_pkg::OP_READ);
			end
			for (int i = int'(ph_ab); i > 0; i--)
				frame.push_back(a24[8*(i-1) +: 8]);
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
			repeat (n) frame.push_back(see_pkg::byte_t'($urandom));
		end else begin
			// noise: raw bytes with arbitrary select flags
			repeat ($urandom_range(1, 4)) push_byte(see_pkg::byte_t'($urandom), 1'($urandom));
		end
		// occasionally cut a command short
		if (frame.size() > 1 && $urandom_range(0, 19) == 0) begin
			n = $urandom_range(1, frame.size() - 1);
			while (frame.size() > n) void'(frame.pop_back());
		end
		foreach (frame[i])
			push_byte(frame[i], i != frame.size() - 1);
	endtask

	logic [1:0] ab_plan   [7] = '{2'd2, 2'd3, 2'd0, 2'd1, 2'd1, 2'd3, 2'd2};
	logic [4:0] size_plan [7] = '{5'd16, 5'd17, 5'd31, 5'd0, 5'd17, 5'd9, 5'd12};

	initial begin
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		arst_n <= 1'b0;
		foreach (hot_addr[i])
			hot_addr[i] = see_pkg::addr_t'($urandom);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Registers take writes during the clearing sweep
		set_config(2'd1, 5'd9);
		phase_no = 0;
		tx_eager = 1'b0;
		push_byte(see_pkg::OP_WRITE, 1'b1);
		push_byte(8'h10, 1'b1);
		push_byte(8'hAA, 1'b0);
		push_byte(see_pkg::OP_WREN, 1'b1);
		push_byte(8'h3C, 1'b0);
		push_byte(see_pkg::OP_WRDI, 1'b0);
		push_byte(see_pkg::OP_WREN, 1'b0);
		push_byte(see_pkg::OP_RDSR, 1'b0);
		// write crossing 0xFF into 0x100, drops enable at the end
		push_byte(see_pkg::OP_WRITE, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(see_pkg::OP_WREN, 1'b0);
		push_byte(see_pkg::OP_WRITE_HI, 1'b1);
		push_byte(8'h80, 1'b1);
		push_byte(8'h55, 1'b0);
		push_byte(see_pkg::OP_READ_HI, 1'b1);
		push_byte(8'h80, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(see_pkg::OP_READ, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h00, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(see_pkg::OP_WRSR, 1'b1);
		push_byte(8'h0C, 1'b0);
		push_byte(see_pkg::OP_RDSR, 1'b0);
		push_byte(8'hC7, 1'b0);
		drain();

		// Each phase ends with the sender paused until all replies are in
		for (int p = 0; p < 7; p++) begin
			set_config(ab_plan[p], size_plan[p]);
			phase_no = p + 1;
			while (n_queued < 27 + 132 * (p + 1))
				gen_command();
			drain();
		end

		repeat (8) @(posedge clk);
		if (n_errors == 0 && answers_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
+incdir+hdl
hdl/see_pkg.sv
hdl/see_if.sv
hdl/see_mem.sv
hdl/see_cmd.sv
hdl/spi_eeprom_command_engine.sv
dv/tb_top.sv
